// ----- hdl/bpm_pkg.sv -----
package bpm_pkg;

   // Defaults for the top-level parameters
   localparam int STACK_DEPTH_DEF = 64;
   localparam int POS_WIDTH_DEF   = 16;

   // Fixed field widths on the ports
   localparam int CHAR_W      = 8;
   localparam int OUT_POS_W   = 16;
   localparam int RSP_FIELD_W = 2 + 1 + OUT_POS_W + OUT_POS_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // Bracket characters
   localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_LBRACK = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_RBRACK = 8'h5D;

   typedef enum logic [1:0] {
      KIND_MATCH    = 2'd0,
      KIND_CLOSER   = 2'd1,
      KIND_OPENER   = 2'd2,
      KIND_OVERFLOW = 2'd3
   } result_kind_type;

   // Where the next result word is taken from
   typedef enum logic [1:0] {
      SRC_NOW    = 2'd0,
      SRC_LOOKUP = 2'd1,
      SRC_DRAIN  = 2'd2
   } src_type;

   typedef struct packed {
      logic            advance;   // take the byte's position, step the counter
      logic            restart;   // clear the position counter
      logic            push;      // write opener at the stack top
      logic            pop;       // read the top entry and drop it
      logic            load_out;  // load the result register
      src_type         src;
      result_kind_type kind;      // kind for SRC_NOW results
   } cmd_type;

   typedef struct packed {
      logic is_eot;
      logic is_open;
      logic is_close;
      logic stack_empty;
      logic stack_full;
      logic out_free;
   } status_type;

endpackage

// ----- hdl/bpm_ctrl.sv -----
module bpm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bpm_pkg::status_type status,
   output bpm_pkg::cmd_type    cmd
);
   import bpm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.src  = SRC_NOW;
      cmd.kind = KIND_MATCH;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.is_eot) begin
                  cmd.restart = 1'b1;
                  if (!status.stack_empty) begin
                     cmd.pop  = 1'b1;
                     state_in = ST_DRAIN;
                  end
               end else begin
                  cmd.advance = 1'b1;
                  if (status.is_open) begin
                     if (status.stack_full) begin
                        cmd.load_out = 1'b1;
                        cmd.kind     = KIND_OVERFLOW;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end else if (status.is_close) begin
                     if (status.stack_empty) begin
                        cmd.load_out = 1'b1;
                        cmd.kind     = KIND_CLOSER;
                     end else begin
                        cmd.pop  = 1'b1;
                        state_in = ST_LOOKUP;
                     end
                  end
               end
            end
         end
         ST_LOOKUP: begin
            // result register is free here: nothing loaded it since accept
            cmd.load_out = 1'b1;
            cmd.src      = SRC_LOOKUP;
            state_in     = ST_IDLE;
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.src      = SRC_DRAIN;
               if (status.stack_empty) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.pop = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/bpm_dp.sv -----
module bpm_dp #(
   parameter int STACK_DEPTH = bpm_pkg::STACK_DEPTH_DEF,
   parameter int POS_WIDTH   = bpm_pkg::POS_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bpm_pkg::CHAR_W-1:0]          char_code,
   input  logic                                end_of_text,
   input  bpm_pkg::cmd_type                    cmd,
   output bpm_pkg::status_type                 status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output bpm_pkg::result_kind_type            result_kind,
   output logic                                bracket_kind,
   output logic [bpm_pkg::OUT_POS_W-1:0]       open_position,
   output logic [bpm_pkg::OUT_POS_W-1:0]       close_position,
   output logic                                last_of_run
);
   import bpm_pkg::*;

   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int ENTRY_W = POS_WIDTH + 1;
   localparam int EXT_W   = (POS_WIDTH > OUT_POS_W) ? POS_WIDTH : OUT_POS_W;

   logic [ENTRY_W-1:0]   stack_mem_ff [STACK_DEPTH];
   logic [ENTRY_W-1:0]   rd_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [POS_WIDTH-1:0] pos_ff;
   logic [POS_WIDTH-1:0] here_ff;
   logic                 bk_ff;
   logic                 out_valid_ff;
   result_kind_type      kind_ff;
   logic                 bk_out_ff;
   logic [OUT_POS_W-1:0] open_ff;
   logic [OUT_POS_W-1:0] close_ff;
   logic                 last_ff;

   result_kind_type      kind_in;
   logic                 bk_out_in;
   logic [OUT_POS_W-1:0] open_in;
   logic [OUT_POS_W-1:0] close_in;
   logic                 last_in;

   logic                 char_bk;
   logic [ADDR_W-1:0]    top_addr;
   logic [ADDR_W-1:0]    push_addr;
   logic                 rd_bk;
   logic [EXT_W-1:0]     rd_pos_ext;
   logic [EXT_W-1:0]     pos_ext;
   logic [EXT_W-1:0]     here_ext;

   assign char_bk   = (char_code == CHAR_LBRACK) || (char_code == CHAR_RBRACK);
   assign top_addr  = ADDR_W'(count_ff - 1'b1);
   assign push_addr = ADDR_W'(count_ff);
   assign rd_bk      = rd_ff[ENTRY_W-1];
   assign rd_pos_ext = EXT_W'(rd_ff[POS_WIDTH-1:0]);
   assign pos_ext    = EXT_W'(pos_ff);
   assign here_ext   = EXT_W'(here_ff);

   assign status.is_eot      = end_of_text;
   assign status.is_open     = (char_code == CHAR_LPAREN) || (char_code == CHAR_LBRACK);
   assign status.is_close    = (char_code == CHAR_RPAREN) || (char_code == CHAR_RBRACK);
   assign status.stack_empty = (count_ff == '0);
   assign status.stack_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign status.out_free    = !out_valid_ff || rsp_ready;

   // Stack memory: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem_ff[push_addr] <= {char_bk, pos_ff};
      end
      if (cmd.pop) begin
         rd_ff <= stack_mem_ff[top_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         if (cmd.push) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.pop) begin
            count_ff <= count_ff - 1'b1;
         end
         if (cmd.restart) begin
            pos_ff <= '0;
         end else if (cmd.advance && (pos_ff != '1)) begin
            pos_ff <= pos_ff + 1'b1;
         end
      end
   end

   // Hold the closer's kind and position across the stack read
   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         bk_ff   <= char_bk;
         here_ff <= pos_ff;
      end
   end

   always_comb begin
      case (cmd.src)
         SRC_LOOKUP: begin
            bk_out_in = bk_ff;
            close_in  = here_ext[OUT_POS_W-1:0];
            last_in   = 1'b1;
            if (rd_bk == bk_ff) begin
               kind_in = KIND_MATCH;
               open_in = rd_pos_ext[OUT_POS_W-1:0];
            end else begin
               kind_in = KIND_CLOSER;
               open_in = '0;
            end
         end
         SRC_DRAIN: begin
            kind_in   = KIND_OPENER;
            bk_out_in = rd_bk;
            open_in   = rd_pos_ext[OUT_POS_W-1:0];
            close_in  = '0;
            last_in   = status.stack_empty;
         end
         default: begin
            kind_in   = cmd.kind;
            bk_out_in = char_bk;
            open_in   = '0;
            close_in  = pos_ext[OUT_POS_W-1:0];
            last_in   = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         kind_ff   <= kind_in;
         bk_out_ff <= bk_out_in;
         open_ff   <= open_in;
         close_ff  <= close_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign result_kind    = kind_ff;
   assign bracket_kind   = bk_out_ff;
   assign open_position  = open_ff;
   assign close_position = close_ff;
   assign last_of_run    = last_ff;

endmodule

// ----- hdl/bracket_pair_matcher.sv -----
// Bracket pair matcher. Each request word carries one text byte in req_tdata,
// or, with req_tuser high, an end-of-text mark. Every byte takes the current
// position (counting from 0, holding at 2^POS_WIDTH - 1) and advances it.
// Round and square openers go onto a stack of STACK_DEPTH entries; a closer
// pops the top and reports a matched pair, or an unmatched closer if the kinds
// differ or the stack is empty. An opener meeting a full stack is dropped and
// reported as overflow. End of text clears the position and reports each
// leftover opener, top first, emptying the stack. rsp_tlast marks the last
// response word caused by one request word. A closer that meets a stacked
// opener passes through a lookup state, as the stack sits in a memory with
// a registered read port; end of text drains the leftover openers before a
// new word is taken. Response backpressure stalls the matcher; one result
// register parts the two sides so a new word is taken in the cycle the
// waiting result is taken.
module bracket_pair_matcher #(
   parameter int STACK_DEPTH = bpm_pkg::STACK_DEPTH_DEF,
   parameter int POS_WIDTH   = bpm_pkg::POS_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bpm_pkg::CHAR_W-1:0]       req_tdata,   // [7:0] char_code
   input  logic                             req_tuser,   // [0] end_of_text
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] result_kind, [2] bracket_kind, [18:3] open_position,
   // [34:19] close_position, [39:35] zero
   output logic [bpm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast    // last_of_run
);
   import bpm_pkg::*;

   cmd_type              cmd;
   status_type           status;
   result_kind_type      result_kind;
   logic                 bracket_kind;
   logic [OUT_POS_W-1:0] open_position;
   logic [OUT_POS_W-1:0] close_position;

   bpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   bpm_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .POS_WIDTH   (POS_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .char_code      (req_tdata),
      .end_of_text    (req_tuser),
      .cmd            (cmd),
      .status         (status),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .result_kind    (result_kind),
      .bracket_kind   (bracket_kind),
      .open_position  (open_position),
      .close_position (close_position),
      .last_of_run    (rsp_tlast)
   );

   // Pack the response word, first field in the low bits, pad with zeros
   assign rsp_tdata = RSP_DATA_W'({close_position, open_position, bracket_kind, result_kind});

endmodule

// ----- hdl/bpm_checker.sv -----
module bpm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bpm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import bpm_pkg::*;

   logic [1:0]           kind;
   logic [OUT_POS_W-1:0] open_pos;
   logic [OUT_POS_W-1:0] close_pos;

   assign kind      = rsp_tdata[1:0];
   assign open_pos  = rsp_tdata[OUT_POS_W+2:3];
   assign close_pos = rsp_tdata[2*OUT_POS_W+2:OUT_POS_W+3];

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Leftover openers carry no closing position
   a_opener_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (kind == KIND_OPENER) |-> close_pos == '0)
      else $error("leftover opener with closing position");

   // Closer and overflow results have no opener and end their run
   a_single_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((kind == KIND_CLOSER) || (kind == KIND_OVERFLOW))
      |-> (open_pos == '0) && rsp_tlast)
      else $error("closer or overflow result malformed");

   // Pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_FIELD_W] == '0)
      else $error("response pad bits not zero");

endmodule

bind bracket_pair_matcher bpm_checker u_bpm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
